FILE: rtl/vlq_pkg.sv
// Shared types and constants for the LEB128 varint codec.
package vlq_pkg;

  localparam int unsigned GRP_W = 4;

  typedef enum logic {
    ACTION_ENCODE = 1'b0,
    ACTION_DECODE = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_VALUE = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  localparam logic [7:0] CONT_BIT     = 8'h80;
  localparam logic [6:0] PAYLOAD_MASK = 7'h7f;

  typedef struct packed {
    logic load_enc;
    logic step_enc;
    logic dec_beat;
    logic dec_emit;
  } vlq_cmd_t;

  typedef struct packed {
    logic enc_last;
  } vlq_sts_t;

endpackage

FILE: rtl/varint_vlq_codec.sv
// Top level of the unsigned LEB128 varint encoder and decoder.
// Decode: one byte beat per cycle; the result of a final byte shows the next cycle.
// Encode: the beat loads the shift register, then one byte per cycle while the output is free;
// an item holds the input off until its last byte steps out of the encode shift register.
// A stalled output holds the input off; one result register parts the two sides.
// Reset clears the decode accumulator, group count, overflow flag and output valid.
module varint_vlq_codec
  import vlq_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [63:0] value_in_i,
  input  logic [7:0]  byte_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  byte_out_o,
  output logic        last_o,
  output logic [63:0] value_out_o
);

  vlq_cmd_t cmd;
  vlq_sts_t sts;

  vlq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .more_i      (byte_in_i[7]),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  vlq_dpath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .value_in_i  (value_in_i),
    .byte_in_i   (byte_in_i),
    .kind_o      (kind_o),
    .byte_out_o  (byte_out_o),
    .last_o      (last_o),
    .value_out_o (value_out_o)
  );

endmodule

FILE: rtl/vlq_ctrl.sv
// Controller: input and output handshakes, encode run sequencing.
module vlq_ctrl
  import vlq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     action_i,
  input  logic     more_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output vlq_cmd_t cmd_o,
  input  vlq_sts_t sts_i
);

  typedef enum logic {
    S_IDLE,
    S_ENC
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;
  logic   in_beat;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE) && slot_free;
  assign in_beat     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          if (action_i == ACTION_ENCODE) begin
            cmd_o.load_enc = 1'b1;
            state_d        = S_ENC;
          end else begin
            cmd_o.dec_beat = 1'b1;
            if (!more_i) begin
              cmd_o.dec_emit = 1'b1;
              out_valid_d    = 1'b1;
            end
          end
        end
      end
      S_ENC: begin
        if (slot_free) begin
          cmd_o.step_enc = 1'b1;
          out_valid_d    = 1'b1;
          if (sts_i.enc_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: rtl/vlq_dpath.sv
// Datapath: encode shift register, decode accumulator and result register.
module vlq_dpath
  import vlq_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  vlq_cmd_t    cmd_i,
  output vlq_sts_t    sts_o,
  input  logic [63:0] value_in_i,
  input  logic [7:0]  byte_in_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  byte_out_o,
  output logic        last_o,
  output logic [63:0] value_out_o
);

  localparam int unsigned GroupLimit = (VALUE_BITS + 6) / 7;
  localparam int unsigned WideBits   = VALUE_BITS + 7;

  logic [VALUE_BITS-1:0] enc_q, enc_d;
  logic [VALUE_BITS-1:0] enc_rem;

  logic [VALUE_BITS-1:0] acc_q, acc_d, acc_next;
  logic [GRP_W-1:0]      grp_q, grp_d, grp_next;
  logic                  ovf_q, ovf_d, ovf_next;
  logic                  grp_full;
  logic [6:0]            shamt;
  logic [WideBits-1:0]   dec_shift;

  logic [1:0]  kind_q, kind_d;
  logic [7:0]  byte_q, byte_d;
  logic        last_q, last_d;
  logic [63:0] value_q, value_d;

  assign enc_rem        = enc_q >> 7;
  assign sts_o.enc_last = (enc_rem == '0);

  assign grp_full  = (grp_q >= GRP_W'(GroupLimit));
  assign shamt     = {grp_q, 3'b000} - {3'b000, grp_q};
  assign dec_shift = {{VALUE_BITS{1'b0}}, byte_in_i[6:0] & PAYLOAD_MASK} << shamt;

  always_comb begin
    if (grp_full) begin
      acc_next = acc_q;
      grp_next = grp_q;
      ovf_next = 1'b1;
    end else begin
      acc_next = acc_q | dec_shift[VALUE_BITS-1:0];
      grp_next = grp_q + GRP_W'(1);
      ovf_next = ovf_q || (dec_shift[WideBits-1:VALUE_BITS] != '0);
    end
  end

  always_comb begin
    enc_d   = enc_q;
    acc_d   = acc_q;
    grp_d   = grp_q;
    ovf_d   = ovf_q;
    kind_d  = kind_q;
    byte_d  = byte_q;
    last_d  = last_q;
    value_d = value_q;
    if (cmd_i.load_enc) begin
      enc_d = value_in_i[VALUE_BITS-1:0];
    end
    if (cmd_i.step_enc) begin
      enc_d   = enc_rem;
      kind_d  = KIND_BYTE;
      byte_d  = {(enc_rem != '0), enc_q[6:0]};
      last_d  = (enc_rem == '0);
      value_d = '0;
    end
    if (cmd_i.dec_beat) begin
      acc_d = acc_next;
      grp_d = grp_next;
      ovf_d = ovf_next;
    end
    if (cmd_i.dec_emit) begin
      acc_d   = '0;
      grp_d   = '0;
      ovf_d   = 1'b0;
      kind_d  = ovf_next ? KIND_ERROR : KIND_VALUE;
      byte_d  = '0;
      last_d  = 1'b1;
      value_d = ovf_next ? 64'd0 : 64'(acc_next);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      grp_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      grp_q <= grp_d;
      ovf_q <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    enc_q   <= enc_d;
    kind_q  <= kind_d;
    byte_q  <= byte_d;
    last_q  <= last_d;
    value_q <= value_d;
  end

  assign kind_o      = kind_q;
  assign byte_out_o  = byte_q;
  assign last_o      = last_q;
  assign value_out_o = value_q;

endmodule

FILE: rtl/vlq_checker.sv
// Port-level checker for the varint codec, bound to the top level.
module vlq_checker
  import vlq_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        action_i,
  input logic [7:0]  byte_in_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  kind_o,
  input logic [7:0]  byte_out_o,
  input logic        last_o,
  input logic [63:0] value_out_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) && $stable(byte_out_o)
      && $stable(last_o) && $stable(value_out_o))
    else $error("stalled output beat changed");

  a_enc_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && action_i == ACTION_ENCODE |=> !in_ready_o)
    else $error("input taken while an encode run starts");

  a_dec_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && action_i == ACTION_DECODE && !byte_in_i[7] |=> out_valid_o
      && (kind_o == KIND_VALUE || kind_o == KIND_ERROR))
    else $error("final decode byte gave no result");

  a_byte_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_BYTE |-> (byte_out_o[7] == !last_o) && value_out_o == '0)
    else $error("encoded byte continuation bit disagrees with last");

  a_dec_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_BYTE |-> last_o && byte_out_o == '0
      && (kind_o == KIND_VALUE || value_out_o == '0))
    else $error("malformed decode result");

endmodule

bind varint_vlq_codec vlq_checker u_vlq_checker (.*);

FILE: test/varint_vlq_codec_tb.sv
// Self-checking testbench for the LEB128 varint codec: encode and decode beats against a predictor.
`timescale 1ns / 100ps

module varint_vlq_codec_tb;
  import vlq_pkg::*;

  localparam int unsigned VALUE_BITS   = 64;
  localparam int unsigned GROUP_BITS   = 7;
  localparam int unsigned GROUP_LIMIT  = (VALUE_BITS + GROUP_BITS - 1) / GROUP_BITS;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  byte_out;
    logic        last;
    logic [63:0] value_out;
  } codec_result_t;

  class leb128_scoreboard;
    codec_result_t pending_results[$];
    logic [63:0]   dec_acc;
    int unsigned   dec_groups;
    bit            dec_overflow;
    int unsigned   mismatches;

    function new();
      dec_acc      = '0;
      dec_groups   = 0;
      dec_overflow = 1'b0;
      mismatches   = 0;
    endfunction

    function int unsigned backlog();
      return pending_results.size();
    endfunction

    function void take_input_beat(action_e act, logic [63:0] val, logic [7:0] byt);
      codec_result_t r;
      logic [63:0]   rest;
      logic [6:0]    payload;
      int unsigned   shift;
      int unsigned   room;
      if (act == ACTION_ENCODE) begin
        rest = val;
        do begin
          r.kind     = KIND_BYTE;
          r.byte_out = {1'b0, rest[6:0] & PAYLOAD_MASK};
          rest       = rest >> GROUP_BITS;
          if (rest != '0) r.byte_out = r.byte_out | CONT_BIT;
          r.last      = (rest == '0);
          r.value_out = '0;
          pending_results.push_back(r);
        end while (rest != '0);
      end else begin
        payload = byt[6:0] & PAYLOAD_MASK;
        if (dec_groups >= GROUP_LIMIT) begin
          dec_overflow = 1'b1;
        end else begin
          shift = GROUP_BITS * dec_groups;
          room  = VALUE_BITS - shift;
          if (room < GROUP_BITS && (payload >> room) != '0) dec_overflow = 1'b1;
          dec_acc    = dec_acc | (64'(payload) << shift);
          dec_groups = dec_groups + 1;
        end
        if ((byt & CONT_BIT) == '0) begin
          r.kind      = dec_overflow ? KIND_ERROR : KIND_VALUE;
          r.byte_out  = '0;
          r.last      = 1'b1;
          r.value_out = dec_overflow ? '0 : dec_acc;
          pending_results.push_back(r);
          dec_acc      = '0;
          dec_groups   = 0;
          dec_overflow = 1'b0;
        end
      end
    endfunction

    function void check_output_beat(logic [1:0] kind, logic [7:0] byt, logic last,
                                    logic [63:0] val);
      codec_result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result kind %0d byte %02h last %0b value %016h",
                   $time, kind, byt, last, val);
      end else begin
        want = pending_results.pop_front();
        if (want.kind !== kind || want.byte_out !== byt || want.last !== last ||
            want.value_out !== val) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: mismatch expected kind %0d byte %02h last %0b value %016h",
                     $time, want.kind, want.byte_out, want.last, want.value_out);
            $display("%0t: mismatch actual   kind %0d byte %02h last %0b value %016h",
                     $time, kind, byt, last, val);
          end
        end
      end
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic        action_i    = 1'b0;
  logic [63:0] value_in_i  = '0;
  logic [7:0]  byte_in_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  kind_o;
  logic [7:0]  byte_out_o;
  logic        last_o;
  logic [63:0] value_out_o;

  leb128_scoreboard sb = new();

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned beats_sent     = 0;
  int unsigned cycles         = 0;
  bit          hold_request   = 1'b0;

  varint_vlq_codec #(
    .VALUE_BITS(VALUE_BITS)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .action_i   (action_i),
    .value_in_i (value_in_i),
    .byte_in_i  (byte_in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .kind_o     (kind_o),
    .byte_out_o (byte_out_o),
    .last_o     (last_o),
    .value_out_o(value_out_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  task automatic drive_item(input action_e act, input logic [63:0] val,
                            input logic [7:0] byt);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    value_in_i <= val;
    byte_in_i  <= byt;
    do @(posedge clk_i); while (!in_ready_o);
    sb.take_input_beat(act, val, byt);
    beats_sent++;
  endtask

  task automatic send_encode(input logic [63:0] val);
    drive_item(ACTION_ENCODE, val, 8'($urandom));
  endtask

  task automatic send_decode(input logic [7:0] byt);
    drive_item(ACTION_DECODE, {$urandom, $urandom}, byt);
  endtask

  function automatic logic [63:0] random_value();
    logic [63:0] v;
    v = {$urandom, $urandom};
    if ($urandom_range(7) == 0) return $urandom_range(1) ? '1 : '0;
    return v >> $urandom_range(63);
  endfunction

  task automatic send_number(input logic [63:0] val, input bit pad, input bit mix);
    logic [7:0]  seq[$];
    logic [63:0] rest;
    logic [7:0]  b;
    rest = val;
    do begin
      b    = {1'b0, rest[6:0]};
      rest = rest >> GROUP_BITS;
      if (rest != '0) b = b | CONT_BIT;
      seq.push_back(b);
    end while (rest != '0);
    while (pad && seq.size() < GROUP_LIMIT && $urandom_range(1)) begin
      seq[seq.size() - 1] = seq[seq.size() - 1] | CONT_BIT;
      seq.push_back(8'h00);
    end
    foreach (seq[i]) begin
      if (mix && i != 0 && $urandom_range(99) < 25) send_encode(random_value());
      send_decode(seq[i]);
    end
  endtask

  task automatic send_random_burst();
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(99);
    if (pick < 35) begin
      send_encode(random_value());
    end else if (pick < 80) begin
      send_number(random_value(), $urandom_range(99) < 15, $urandom_range(99) < 20);
    end else if (pick < 88) begin
      len = $urandom_range(13, GROUP_LIMIT + 1);
      repeat (len - 1) send_decode(CONT_BIT | 8'($urandom_range(127)));
      send_decode(8'($urandom_range(127)));
    end else if (pick < 94) begin
      repeat (GROUP_LIMIT - 1) send_decode(CONT_BIT | 8'($urandom_range(127)));
      send_decode(8'($urandom_range(127, 2)));
    end else begin
      send_decode(8'($urandom));
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.backlog() != 0);
  endtask

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                           input int unsigned count);
    int unsigned target;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    target = beats_sent + count;
    while (beats_sent < target) send_random_burst();
  endtask

  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i)
        sb.check_output_beat(kind_o, byte_out_o, last_o, value_out_o);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin : watchdog
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("varint_vlq_codec verification failed");
    $finish;
  end

  initial begin : stimulus
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_encode(64'd0);
    send_encode(64'd1);
    send_encode(64'd127);
    send_encode(64'd128);
    send_encode('1);
    send_encode(64'h8000_0000_0000_0000);
    send_decode(8'h00);
    send_decode(8'h7f);
    send_decode(8'h85);
    send_encode(64'd300);
    send_decode(8'h01);
    repeat (GROUP_LIMIT - 1) send_decode(8'h80);
    send_decode(8'h02);
    wait_drained();

    run_phase(0, 0, 90);
    run_phase(55, 0, 90);
    run_phase(0, 55, 90);
    run_phase(10, 10, 90);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 1'b1;
    repeat (30) send_encode('1);
    wait_drained();

    run_phase(0, 0, 60);
    run_phase(55, 55, 40);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.backlog() == 0) begin
      $display("varint_vlq_codec verification clean");
    end else begin
      $display("varint_vlq_codec verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/vlq_pkg.sv
rtl/vlq_ctrl.sv
rtl/vlq_dpath.sv
rtl/varint_vlq_codec.sv
rtl/vlq_checker.sv
test/varint_vlq_codec_tb.sv
